>>> rtl/rwot_pkg.sv
package rwot_pkg;

	localparam int KIND_W          = 3;
	localparam int ID_W            = 16;
	localparam int OFF_W           = 16;
	localparam int STATUS_W        = 2;
	localparam int DEF_TABLE_SLOTS = 8;

	// modulo dividend: offset plus frame count
	localparam int DIV_W = OFF_W + 1;

	localparam logic [OFF_W-1:0] BUF_SIZE_RST = 16'd4096;

	// command kinds
	localparam logic [KIND_W-1:0] KIND_ADD       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FRAMES    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NEW_POINT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd4;

	// result status
	localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STS_PRESENT   = 2'd1;
	localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STS_FULL      = 2'd3;

	typedef struct packed {
		logic             wr_en;
		logic             set_vld;
		logic             clr_vld;
		logic [ID_W-1:0]  writer;
		logic [OFF_W-1:0] off;
	} tbl_wr_t;

	typedef struct packed {
		logic             vld;
		logic [ID_W-1:0]  writer;
		logic [OFF_W-1:0] off;
	} tbl_rd_t;

endpackage

>>> rtl/rwot_table.sv
module rwot_table #(
	parameter int SLOTS = rwot_pkg::DEF_TABLE_SLOTS,
	parameter int IDX_W = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_idx,
	output rwot_pkg::tbl_rd_t    rd,
	input  logic [IDX_W-1:0]     wr_idx,
	input  rwot_pkg::tbl_wr_t    wr
);
	import rwot_pkg::*;

	localparam int WORD_W = ID_W + OFF_W;

	logic [SLOTS-1:0]  vld_q;
	logic [SLOTS-1:0]  wrt_q;   // entry written since reset
	logic [WORD_W-1:0] mem [SLOTS];
	logic [WORD_W-1:0] word_s1;
	logic              vld_s1;
	logic              wrt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			wrt_q <= '0;
		end else begin
			if (wr.set_vld)
				vld_q[wr_idx] <= 1'b1;
			if (wr.clr_vld)
				vld_q[wr_idx] <= 1'b0;
			if (wr.wr_en)
				wrt_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.wr_en)
			mem[wr_idx] <= {wr.writer, wr.off};
		if (rd_en) begin
			word_s1 <= mem[rd_idx];
			vld_s1  <= vld_q[rd_idx];
			wrt_s1  <= wrt_q[rd_idx];
		end
	end

	// unwritten entries read as zero
	assign rd.vld    = vld_s1;
	assign rd.writer = wrt_s1 ? word_s1[WORD_W-1:OFF_W] : '0;
	assign rd.off    = wrt_s1 ? word_s1[OFF_W-1:0] : '0;

endmodule

>>> rtl/ring_writer_offset_tracker.sv
// Channel | Dir | Fields                          | Handshake
// cmd     | in  | kind, writer_id, frame_count    | cmd_valid / cmd_stall
// rsp     | out | status, value                   | rsp_valid / rsp_stall
// cfg     | in  | buffer_size at byte 0           | APB write, pready tied high
//
// A command runs from transfer to result as follows: the table is
// scanned one slot a cycle through the single read port, then the read data
// register, the finish state and the load of the result register follow.
// Frames-added on a known writer also runs the modulo, bit-serially on
// the shared subtractor, before the result is loaded.
// cmd_stall is high from the cycle after a transfer until the block is idle again;
// a result waiting under rsp_stall does not stop the next command being taken.
// Reset clears the slot valid bits and the common point and sets buffer_size to 4096.
module ring_writer_offset_tracker #(
	parameter int TABLE_SLOTS = rwot_pkg::DEF_TABLE_SLOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  logic [rwot_pkg::KIND_W-1:0]    kind,
	input  logic [rwot_pkg::ID_W-1:0]      writer_id,
	input  logic [rwot_pkg::OFF_W-1:0]     frame_count,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [rwot_pkg::STATUS_W-1:0]  status,
	output logic [rwot_pkg::OFF_W-1:0]     value
);
	import rwot_pkg::*;

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
	localparam int CNT_W = $clog2(DIV_W);
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DIV_W - 1);

	// register index taken from paddr[2]
	localparam logic REG_BUFFER_SIZE = 1'b0;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_FIN  = 3'd2;
	localparam logic [2:0] S_MOD  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	// ---------------------------------------------------------------
	// configuration
	// ---------------------------------------------------------------
	logic [OFF_W-1:0] bsize_q;
	logic [OFF_W-1:0] esize;       // zero size acts as one
	logic             cfg_wr;

	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BUFFER_SIZE) ? {16'b0, bsize_q} : '0;
	assign esize  = (bsize_q == '0) ? OFF_W'(1) : bsize_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bsize_q <= BUF_SIZE_RST;
		else if (cfg_wr && paddr[2] == REG_BUFFER_SIZE)
			bsize_q <= pwdata[OFF_W-1:0];
	end

	// ---------------------------------------------------------------
	// sequencer state and scan pipeline
	// ---------------------------------------------------------------
	logic [2:0]       state_q;
	logic             iss_q;       // scan reads still being issued
	logic [IDX_W-1:0] rd_idx_q;
	logic             rv_s1;       // table read data valid
	logic [IDX_W-1:0] idx_s1;
	logic             hit_q;
	logic             free_q;
	logic [CNT_W-1:0] mod_cnt_q;
	logic [OFF_W-1:0] cp_q;        // common write point
	logic             rsp_valid_q;

	// captured command
	logic [KIND_W-1:0] kind_q;
	logic [ID_W-1:0]   id_q;
	logic [OFF_W-1:0]  frames_q;

	// scan results
	logic [IDX_W-1:0] hit_idx_q;
	logic [OFF_W-1:0] hit_off_q;
	logic [OFF_W-1:0] hit_dist_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [OFF_W-1:0] best_q;
	logic [OFF_W-1:0] best_off_q;

	// modulo unit state
	logic [OFF_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;

	// result staging and output register
	logic [STATUS_W-1:0] res_status_q;
	logic [OFF_W-1:0]    res_value_q;
	logic [STATUS_W-1:0] res_status_d;
	logic [OFF_W-1:0]    res_value_d;
	logic [STATUS_W-1:0] status_q;
	logic [OFF_W-1:0]    value_q;

	logic cmd_xfer;
	logic rsp_free;
	logic rsp_load;
	logic scan_last;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_xfer  = cmd_valid & ~cmd_stall;
	assign rsp_free  = ~rsp_valid_q | ~rsp_stall;
	assign rsp_load  = (state_q == S_DONE) && rsp_free;
	assign scan_last = rv_s1 && (idx_s1 == LAST_IDX);

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign value     = value_q;

	// ---------------------------------------------------------------
	// slot table
	// ---------------------------------------------------------------
	tbl_rd_t          rd;
	tbl_wr_t          wr;
	logic [IDX_W-1:0] wr_idx;
	logic             rd_en;

	assign rd_en = (state_q == S_SCAN) && iss_q;

	rwot_table #(
		.SLOTS (TABLE_SLOTS),
		.IDX_W (IDX_W)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_idx (rd_idx_q),
		.rd     (rd),
		.wr_idx (wr_idx),
		.wr     (wr)
	);

	// ---------------------------------------------------------------
	// shared subtractor: forward distance during the scan,
	// restoring modulo step in S_MOD
	// ---------------------------------------------------------------
	logic [DIV_W-1:0] sub_a;
	logic [OFF_W-1:0] sub_b;
	logic [DIV_W:0]   sub_d;       // signed, top bit is the borrow
	logic [OFF_W-1:0] rem_next;

	always_comb begin
		if (state_q == S_MOD) begin
			sub_a = {rem_q, div_q[DIV_W-1]};
			sub_b = esize;
		end else begin
			// behind the common point: wrap by one buffer length
			sub_a = (rd.off < cp_q) ? ({1'b0, rd.off} + {1'b0, esize}) : {1'b0, rd.off};
			sub_b = cp_q;
		end
	end

	assign sub_d    = {1'b0, sub_a} - {2'b0, sub_b};
	assign rem_next = sub_d[DIV_W] ? sub_a[OFF_W-1:0] : sub_d[OFF_W-1:0];

	// per-slot decisions on the word coming out of the table
	logic slot_hit;
	logic slot_free;
	logic slot_best;

	assign slot_hit  = rv_s1 && rd.vld && (rd.writer == id_q) && !hit_q;
	assign slot_free = rv_s1 && !rd.vld && !free_q;
	assign slot_best = rv_s1 && rd.vld && !sub_d[DIV_W]
	                   && (sub_d[DIV_W-1:0] < {1'b0, best_q});

	// ---------------------------------------------------------------
	// table writes: add and remove in S_FIN, new offset at the end of S_MOD
	// ---------------------------------------------------------------
	always_comb begin
		wr     = '0;
		wr_idx = hit_idx_q;
		if (state_q == S_FIN) begin
			if (kind_q == KIND_ADD && !hit_q && free_q) begin
				wr.wr_en   = 1'b1;
				wr.set_vld = 1'b1;
				wr.writer  = id_q;
				wr.off     = cp_q;
				wr_idx     = free_idx_q;
			end else if (kind_q == KIND_REMOVE && hit_q) begin
				wr.clr_vld = 1'b1;
			end
		end else if (state_q == S_MOD && mod_cnt_q == '0) begin
			wr.wr_en  = 1'b1;
			wr.writer = id_q;
			wr.off    = rem_next;
		end
	end

	// result of the command, staged in S_FIN
	always_comb begin
		res_status_d = STS_OK;
		res_value_d  = '0;
		unique case (kind_q)
			KIND_ADD: begin
				if (hit_q)
					res_status_d = STS_PRESENT;
				else if (!free_q)
					res_status_d = STS_FULL;
			end
			KIND_REMOVE: begin
				if (!hit_q)
					res_status_d = STS_NOT_FOUND;
			end
			KIND_NEW_POINT: begin
				res_value_d = best_q;
			end
			KIND_QUERY: begin
				if (hit_q)
					res_value_d = hit_dist_q;
				else
					res_status_d = STS_NOT_FOUND;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iss_q       <= 1'b0;
			rd_idx_q    <= '0;
			rv_s1       <= 1'b0;
			idx_s1      <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			mod_cnt_q   <= '0;
			cp_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rv_s1  <= rd_en;
			idx_s1 <= rd_idx_q;
			if (slot_hit)
				hit_q <= 1'b1;
			if (slot_free)
				free_q <= 1'b1;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (cmd_xfer) begin
						state_q  <= S_SCAN;
						iss_q    <= 1'b1;
						rd_idx_q <= '0;
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
					end
				end
				S_SCAN: begin
					if (iss_q) begin
						if (rd_idx_q == LAST_IDX)
							iss_q <= 1'b0;
						else
							rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (scan_last)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (kind_q == KIND_FRAMES && hit_q) begin
						state_q   <= S_MOD;
						mod_cnt_q <= CNT_TOP;
					end else begin
						state_q <= S_DONE;
					end
					if (kind_q == KIND_NEW_POINT)
						cp_q <= best_off_q;
				end
				S_MOD: begin
					mod_cnt_q <= mod_cnt_q - 1'b1;
					if (mod_cnt_q == '0)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// datapath registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			kind_q   <= kind;
			id_q     <= writer_id;
			frames_q <= frame_count;
			best_q   <= esize;
		end

		if (slot_hit) begin
			hit_idx_q  <= idx_s1;
			hit_off_q  <= rd.off;
			hit_dist_q <= sub_d[OFF_W-1:0];
		end
		if (slot_free)
			free_idx_q <= idx_s1;
		if (slot_best) begin
			best_q     <= sub_d[OFF_W-1:0];
			best_off_q <= rd.off;
		end else if (rv_s1 && idx_s1 == '0) begin
			// slot 0 offset is the fallback when no writer is valid
			best_off_q <= rd.off;
		end

		if (state_q == S_FIN) begin
			res_status_q <= res_status_d;
			res_value_q  <= res_value_d;
			rem_q        <= '0;
			div_q        <= {1'b0, hit_off_q} + {1'b0, frames_q};
		end

		if (state_q == S_MOD) begin
			rem_q <= rem_next;
			div_q <= {div_q[DIV_W-2:0], 1'b0};
		end

		if (rsp_load) begin
			status_q <= res_status_q;
			value_q  <= res_value_q;
		end
	end

endmodule

>>> rtl/rwot_checker.sv
module rwot_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cmd_valid,
	input logic                           cmd_stall,
	input logic                           rsp_valid,
	input logic                           rsp_stall,
	input logic [rwot_pkg::STATUS_W-1:0]  status,
	input logic [rwot_pkg::OFF_W-1:0]     value
);
	import rwot_pkg::*;

	// busy in the cycle after every command transfer
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while block still idle");

	// a command transfer is never followed next cycle by a fresh result
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && !(rsp_valid && rsp_stall) |=> !rsp_valid)
		else $error("result appeared one cycle after command");

	// failed commands carry no distance
	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STS_PRESENT || status == STS_FULL
		|| status == STS_NOT_FOUND) |-> value == '0)
		else $error("non-zero value with error status");

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(value))
		else $error("result changed under stall");

endmodule

bind ring_writer_offset_tracker rwot_checker u_rwot_checker (.*);

>>> bench/tb.sv
module tb;
	import rwot_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 10;
	localparam int TABLE_SLOTS    = DEF_TABLE_SLOTS;
	// worst command: table scan, read latency, finish, result load, serial modulo
	localparam int SLOWEST_CMD    = TABLE_SLOTS + 3 + 17;
	localparam int SETTLE_CYCLES  = 2 * SLOWEST_CMD;
	localparam int TIMEOUT_CYCLES = 600_000;
	localparam int RANDOM_ITEMS   = 1150;
	localparam int ID_POOL        = 12;
	localparam int HOLDOFF_CYCLES = 400;

	localparam logic [2:0] ADDR_BUFFER_SIZE = 3'd0;

	// kinds the block treats as no-ops
	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = KIND_QUERY + 1'b1;
	localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = '1;

	// ring sizes per random phase, reset size is used for the directed part;
	// the drop to small sizes after large ones leaves stale offsets behind
	localparam int NUM_PHASES = 8;
	localparam logic [OFF_W-1:0] RING_SIZES [NUM_PHASES] = '{
		16'd48000, 16'd1, 16'd65535, 16'd0, 16'd7, 16'd300, 16'd65535, 16'd50
	};

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [OFF_W-1:0]    value;
	} reply_t;

	// Mirror of the writer table; every accepted command queues its reply.
	class writer_table_scoreboard;
		bit               slot_used [TABLE_SLOTS];
		bit [ID_W-1:0]    slot_id   [TABLE_SLOTS];
		bit [OFF_W-1:0]   slot_off  [TABLE_SLOTS];
		bit [OFF_W-1:0]   write_point;
		bit [OFF_W-1:0]   ring_size;
		reply_t           pending_replies [$];
		int               mismatches;
		int               replies_checked;
		int               status_tally [4];
		int               empty_points;
		int               stale_seen;

		function void clear();
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				slot_used[i] = 1'b0;
				slot_id[i]   = '0;
				slot_off[i]  = '0;
			end
			write_point = '0;
			ring_size   = BUF_SIZE_RST;
			pending_replies.delete();
		endfunction

		function int ring_len();
			return (ring_size == 0) ? 1 : int'(ring_size);
		endfunction

		function int find_writer(logic [ID_W-1:0] id);
			for (int i = 0; i < TABLE_SLOTS; i++)
				if (slot_used[i] && slot_id[i] == id)
					return i;
			return -1;
		endfunction

		// may come out negative or past the ring once the size was lowered
		function int forward_distance(logic [OFF_W-1:0] off);
			int d;
			if (off >= write_point)
				d = int'(off) - int'(write_point);
			else
				d = ring_len() - (int'(write_point) - int'(off));
			if (d < 0 || d >= ring_len())
				stale_seen++;
			return d;
		endfunction

		function void note_command(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
				logic [OFF_W-1:0] frames);
			reply_t want;
			int     s;
			int     best;
			int     best_slot;
			int     d;
			bit     any;
			want.status = STS_OK;
			want.value  = '0;
			s = find_writer(id);
			case (k)
				KIND_ADD: begin
					if (s >= 0) begin
						want.status = STS_PRESENT;
					end else begin
						want.status = STS_FULL;
						for (int i = 0; i < TABLE_SLOTS; i++) begin
							if (!slot_used[i] && want.status == STS_FULL) begin
								slot_used[i] = 1'b1;
								slot_id[i]   = id;
								slot_off[i]  = write_point;
								want.status  = STS_OK;
							end
						end
					end
				end
				KIND_REMOVE: begin
					if (s < 0)
						want.status = STS_NOT_FOUND;
					else
						slot_used[s] = 1'b0;
				end
				KIND_FRAMES: begin
					if (s >= 0)
						slot_off[s] = 16'((int'(slot_off[s]) + int'(frames)) % ring_len());
				end
				KIND_NEW_POINT: begin
					best      = ring_len();
					best_slot = 0;
					any       = 1'b0;
					for (int i = 0; i < TABLE_SLOTS; i++) begin
						if (slot_used[i]) begin
							any = 1'b1;
							d   = forward_distance(slot_off[i]);
							if (d >= 0 && d < best) begin
								best      = d;
								best_slot = i;
							end
						end
					end
					if (!any)
						empty_points++;
					write_point = slot_off[best_slot];
					want.value  = 16'(best);
				end
				KIND_QUERY: begin
					if (s < 0)
						want.status = STS_NOT_FOUND;
					else
						want.value = 16'(forward_distance(slot_off[s]));
				end
				default: ;
			endcase
			status_tally[want.status]++;
			pending_replies.push_back(want);
		endfunction

		function void check_reply(logic [STATUS_W-1:0] st, logic [OFF_W-1:0] val);
			reply_t want;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: reply with none due: status %0d value %0d",
						$time, st, val);
				return;
			end
			want = pending_replies.pop_front();
			replies_checked++;
			if (st !== want.status || val !== want.value) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: reply %0d: status %0d value %0d, wanted %0d / %0d",
						$time, replies_checked, st, val, want.status, want.value);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                cmd_valid;
	logic                cmd_stall;
	logic [KIND_W-1:0]   kind;
	logic [ID_W-1:0]     writer_id;
	logic [OFF_W-1:0]    frame_count;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [STATUS_W-1:0] status;
	logic [OFF_W-1:0]    value;

	writer_table_scoreboard sb = new();

	int             burst_left;
	int             commands_sent;
	int             config_errors;
	int             holdoff_left;
	logic [ID_W-1:0] id_pool [ID_POOL];

	ring_writer_offset_tracker #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.kind        (kind),
		.writer_id   (writer_id),
		.frame_count (frame_count),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.value       (value)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Response side: check every transfer against the oldest expected reply.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
			sb.check_reply(status, value);
	end

	// Receiver back-pressure: a long hold-off when asked for, otherwise a
	// rolling pattern of clear, light, heavy and periodic stalling.
	initial begin
		int mode;
		int mode_left;
		int tick;
		mode      = 0;
		mode_left = 0;
		tick      = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (holdoff_left > 0) begin
				rsp_stall = 1'b1;
				holdoff_left--;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0:       rsp_stall = 1'b0;
					1:       rsp_stall = ($urandom_range(0, 3) == 0);
					2:       rsp_stall = ($urandom_range(0, 3) != 0);
					default: rsp_stall = ((tick % 5) < 2);
				endcase
			end
		end
	end

	// Offer one command and hold it until the block takes it. The sender runs
	// in bursts; a new burst may start after an idle gap of random length.
	task automatic issue_command(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
			input logic [OFF_W-1:0] fc);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				@(negedge clk);
				cmd_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		cmd_valid   = 1'b1;
		kind        = k;
		writer_id   = id;
		frame_count = fc;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		sb.note_command(k, id, fc);
		commands_sent++;
	endtask

	task automatic drain_replies();
		@(negedge clk);
		cmd_valid = 1'b0;
		while (sb.pending_replies.size() != 0) @(posedge clk);
	endtask

	// Two-phase APB access; pready is polled though it should be tied high.
	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = ADDR_BUFFER_SIZE;
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Only called with the block idle; the register is read back afterwards.
	task automatic set_ring_size(input logic [OFF_W-1:0] sz);
		logic [31:0] rd;
		apb_access(1'b1, {16'h0000, sz}, rd);
		sb.ring_size = sz;
		apb_access(1'b0, '0, rd);
		if (rd[OFF_W-1:0] !== sz) begin
			config_errors++;
			$display("%0t: buffer_size reads %0d, wrote %0d", $time, rd[OFF_W-1:0], sz);
		end
	endtask

	// Hand-picked sequence at the reset size of 4096.
	task automatic directed_sequence();
		// empty table: size comes back, point moves to slot 0's offset
		issue_command(KIND_NEW_POINT, 16'h0000, 16'h0000);
		issue_command(KIND_QUERY,     16'h1234, 16'h0000);
		issue_command(KIND_REMOVE,    16'h1234, 16'h0000);
		// unknown writer: frames are dropped silently
		issue_command(KIND_FRAMES,    16'h1234, 16'hFFFF);
		issue_command(KIND_ADD,       16'h0000, 16'h0000);
		issue_command(KIND_ADD,       16'hFFFF, 16'hFFFF);
		issue_command(KIND_ADD,       16'h0000, 16'h0000);
		// 65535 frames wrap round the 4096 ring
		issue_command(KIND_FRAMES,    16'hFFFF, 16'hFFFF);
		issue_command(KIND_QUERY,     16'hFFFF, 16'h0000);
		issue_command(KIND_QUERY,     16'h0000, 16'h0000);
		issue_command(KIND_NEW_POINT, 16'hFFFF, 16'h0000);
		issue_command(KIND_FRAMES,    16'h0000, 16'd100);
		issue_command(KIND_NEW_POINT, 16'h0000, 16'h0000);
		// point now at 100, below the writer at 4095: no wrap needed
		issue_command(KIND_QUERY,     16'hFFFF, 16'h0000);
		// fill the table, the new slots tie at the common point
		for (int i = 2; i < TABLE_SLOTS; i++)
			issue_command(KIND_ADD, 16'(i), 16'h0000);
		issue_command(KIND_NEW_POINT, 16'h0000, 16'h0000);
		issue_command(KIND_ADD,       16'h8000, 16'h0000);
		// freed slot 0 is the lowest free one again
		issue_command(KIND_REMOVE,    16'h0000, 16'h0000);
		issue_command(KIND_ADD,       16'hAAAA, 16'h5555);
		issue_command(KIND_SPARE_FIRST, 16'hFFFF, 16'hFFFF);
		issue_command(KIND_SPARE_LAST,  16'h0000, 16'h0000);
	endtask

	// Mostly commands on a small pool of writers so that the table stays busy;
	// some ids and frame counts are fully random.
	task automatic random_phase(input int count, input bit with_holdoff);
		int               done;
		int               pick;
		logic [KIND_W-1:0] k;
		logic [ID_W-1:0]   id;
		logic [OFF_W-1:0]  fc;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 20)      k = KIND_ADD;
			else if (pick < 32) k = KIND_REMOVE;
			else if (pick < 62) k = KIND_FRAMES;
			else if (pick < 80) k = KIND_NEW_POINT;
			else if (pick < 97) k = KIND_QUERY;
			else                k = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
			id = ($urandom_range(0, 9) == 0) ? 16'($urandom)
				: id_pool[$urandom_range(0, ID_POOL - 1)];
			fc = ($urandom_range(0, 7) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, sb.ring_len()));
			issue_command(k, id, fc);
			if (k <= KIND_QUERY)
				done++;
			// receiver goes quiet while commands keep coming
			if (with_holdoff && done == count / 2 && k <= KIND_QUERY)
				holdoff_left = HOLDOFF_CYCLES;
		end
	endtask

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("%0t: timed out, %0d replies outstanding", $time,
			sb.pending_replies.size());
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		cmd_valid     = 1'b0;
		kind          = KIND_ADD;
		writer_id     = '0;
		frame_count   = '0;
		burst_left    = 0;
		commands_sent = 0;
		config_errors = 0;
		holdoff_left  = 0;
		sb.clear();
		foreach (id_pool[i])
			id_pool[i] = 16'($urandom);
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		directed_sequence();
		drain_replies();

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_ring_size(RING_SIZES[p]);
			random_phase(RANDOM_ITEMS / NUM_PHASES, p == 2 || p == 5);
			drain_replies();
		end
		set_ring_size(BUF_SIZE_RST);

		// catch any stray reply after the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("summary: %0d commands, %0d replies checked, %0d ring sizes incl. 0/1/65535",
			commands_sent, sb.replies_checked, NUM_PHASES + 1);
		$display("summary: ok %0d present %0d missing %0d full %0d, empty-table points %0d, stale %0d",
			sb.status_tally[STS_OK], sb.status_tally[STS_PRESENT],
			sb.status_tally[STS_NOT_FOUND], sb.status_tally[STS_FULL],
			sb.empty_points, sb.stale_seen);
		if (sb.mismatches == 0 && config_errors == 0 && sb.pending_replies.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d reply mismatches, %0d register errors", sb.mismatches, config_errors);
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> ring_writer_offset_tracker.f
rtl/rwot_pkg.sv
rtl/rwot_table.sv
rtl/ring_writer_offset_tracker.sv
rtl/rwot_checker.sv
bench/tb.sv
